[rtl/drg_pkg.sv]
`default_nettype none

package drg_pkg;

  localparam int TIME_BITS    = 32;
  localparam int NOTE_ENTRIES = 2048;
  localparam int SLOT_BITS    = $clog2(NOTE_ENTRIES);
  localparam int CFG_BITS     = 24;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [1:0] MODE_SEQ    = 2'd0;
  localparam logic [1:0] MODE_IMPACT = 2'd1;
  localparam logic [1:0] MODE_KICK   = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_SYSTEM   = 4'hF;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OPEN    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEP    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN    = 2'd3;

  localparam logic [6:0] NOTE_DEMUTE_LIMIT = 7'd43;
  localparam logic [6:0] SNARE_FIRST       = 7'd37;
  localparam logic [6:0] SNARE_LAST        = 7'd42;
  localparam logic [6:0] HAT_FIRST         = 7'd44;
  localparam logic [6:0] HAT_LAST          = 7'd49;
  localparam logic [2:0] GROUP_LAST_K      = 3'd5;
  localparam logic [6:0] GAIN_RESET        = 7'd127;
  localparam logic [7:0] VEL_DIVISOR       = 8'd127;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  status_byte;
    logic [6:0]  note_number;
    logic [6:0]  velocity_in;
    logic [11:0] frame_offset;
    logic [13:0] tick_samples;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_status;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [11:0] out_frame;
  } out_item_t;

  typedef struct packed {
    logic [19:0] spacing_frames;
    logic [23:0] open_frames;
    logic        keep_mute_after_release;
    logic [6:0]  velocity_gain;
  } cfg_t;

  typedef struct packed {
    logic                 by_impact;
    logic [TIME_BITS-1:0] ntime;
  } note_entry_t;

  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    note_entry_t          wr_data;
    logic [SLOT_BITS-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic                 op;
    logic [TIME_BITS-1:0] a;
    logic [TIME_BITS-1:0] b;
    logic [TIME_BITS-1:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] res;
    logic                 lt;
    logic                 le;
  } alu_resp_t;

  // Floor of x / 127 for x up to 127 * 127, by a shift and one correction.
  function automatic logic [6:0] div127(input logic [13:0] x);
    logic [7:0] q0;
    logic [7:0] r;
    logic [7:0] q;
    q0 = {1'b0, x[13:7]};
    r  = {1'b0, x[6:0]} + q0;
    q  = q0 + ((r >= VEL_DIVISOR) ? 8'd1 : 8'd0);
    return q[6:0];
  endfunction

endpackage

`default_nettype wire

[rtl/drum_midi_retrigger_gate_top.sv]
// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_stall       drg_pkg::in_item_t
// out      output     out_valid / out_stall     drg_pkg::out_item_t
// cfg      input      cfg_we                    cfg_index, cfg_data
//
// After reset the note memory is cleared while no item is accepted; configuration writes
// are taken throughout. A kick, system message or muted note-on ends at decode; a tick
// passes decode and tick check; commands other than note-on pass decode and emit. A sounding
// note-on passes decode, compare, a group scan in a drum group, write and emit, since
// one subtract/compare unit checks one note-memory entry per cycle; a dropped note-on stops
// at its failing check. The output register frees the input; a stall holds the next result.
`default_nettype none

module drum_midi_retrigger_gate_top (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  drg_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output drg_pkg::out_item_t                 out_data,
  input  wire                                cfg_we,
  input  wire [drg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire [drg_pkg::CFG_BITS-1:0]        cfg_data
);
  import drg_pkg::*;

  cfg_t        cfg;
  alu_req_t    alu_req;
  alu_resp_t   alu_resp;
  mem_req_t    mem_req;
  note_entry_t mem_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spacing_frames          <= '0;
      cfg.open_frames             <= '0;
      cfg.keep_mute_after_release <= 1'b0;
      cfg.velocity_gain           <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPACING: cfg.spacing_frames          <= cfg_data[19:0];
        REG_OPEN:    cfg.open_frames             <= cfg_data[23:0];
        REG_KEEP:    cfg.keep_mute_after_release <= cfg_data[0];
        REG_GAIN:    cfg.velocity_gain           <= cfg_data[6:0];
      endcase
    end
  end

  drg_alu u_alu (
    .req  (alu_req),
    .resp (alu_resp)
  );

  drg_note_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  drg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .alu_req   (alu_req),
    .alu_resp  (alu_resp),
    .mem_req   (mem_req),
    .mem_rd    (mem_rd)
  );

endmodule

`default_nettype wire

[rtl/drg_alu.sv]
`default_nettype none

module drg_alu (
  input  drg_pkg::alu_req_t  req,
  output drg_pkg::alu_resp_t resp
);
  import drg_pkg::*;

  logic [TIME_BITS-1:0] res;

  always_comb begin
    if (req.op == ALU_ADD) begin
      res = req.a + req.b;
    end else begin
      res = req.a - req.b;
    end
  end

  assign resp.res = res;
  assign resp.lt  = (res < req.limit);
  assign resp.le  = (res <= req.limit);

endmodule

`default_nettype wire

[rtl/drg_note_mem.sv]
`default_nettype none

module drg_note_mem (
  input  wire                  clk,
  input  drg_pkg::mem_req_t    req,
  output drg_pkg::note_entry_t rd_data
);
  import drg_pkg::*;

  note_entry_t mem [NOTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

`default_nettype wire

[rtl/drg_seq.sv]
`default_nettype none

module drg_seq (
  input  wire                  clk,
  input  wire                  rst,
  input  drg_pkg::cfg_t        cfg,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  drg_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output drg_pkg::out_item_t   out_data,
  output drg_pkg::alu_req_t    alu_req,
  input  drg_pkg::alu_resp_t   alu_resp,
  output drg_pkg::mem_req_t    mem_req,
  input  drg_pkg::note_entry_t mem_rd
);
  import drg_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_CMP0   = 3'd3;
  localparam logic [2:0] S_GRP    = 3'd4;
  localparam logic [2:0] S_TICK   = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]           state;
  logic [SLOT_BITS-1:0] clr_addr;
  in_item_t             item;
  logic [TIME_BITS-1:0] frame_counter;
  logic [TIME_BITS-1:0] kick_start;
  logic [TIME_BITS-1:0] tsum;
  logic                 kick_held;
  logic                 muting_active;
  logic [2:0]           grp_k;
  logic [13:0]          prod;

  logic [3:0]           cmd;
  logic [3:0]           chan;
  logic                 is_impact;
  logic                 in_snare;
  logic                 in_hat;
  logic [6:0]           grp_first;
  logic                 demute;
  logic [TIME_BITS-1:0] now;
  logic [SLOT_BITS-1:0] own_slot;
  logic                 out_load;
  logic                 in_accept;

  assign cmd       = item.status_byte[7:4];
  assign chan      = item.status_byte[3:0];
  assign is_impact = (item.mode == MODE_IMPACT);
  assign in_snare  = (chan == 4'd0) && (item.note_number >= SNARE_FIRST) &&
                     (item.note_number <= SNARE_LAST);
  assign in_hat    = (chan == 4'd0) && (item.note_number >= HAT_FIRST) &&
                     (item.note_number <= HAT_LAST);
  assign grp_first = in_snare ? SNARE_FIRST : HAT_FIRST;
  assign demute    = !is_impact && !kick_held && muting_active && (cmd == CMD_NOTE_ON) &&
                     (chan <= 4'd1) && (item.note_number < NOTE_DEMUTE_LIMIT);
  assign now       = is_impact ? frame_counter : tsum;
  assign own_slot  = {chan, item.note_number};
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    alu_req = '0;
    unique case (state)
      S_DECODE: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = frame_counter;
        if (item.mode == MODE_TICK) begin
          alu_req.b = TIME_BITS'(item.tick_samples);
        end else begin
          alu_req.b = TIME_BITS'(item.frame_offset);
        end
      end
      S_TICK: begin
        alu_req.op    = ALU_SUB;
        alu_req.a     = frame_counter;
        alu_req.b     = kick_start;
        alu_req.limit = TIME_BITS'(cfg.open_frames);
      end
      default: begin
        alu_req.op    = ALU_SUB;
        alu_req.a     = now;
        alu_req.b     = mem_rd.ntime;
        alu_req.limit = TIME_BITS'(cfg.spacing_frames);
      end
    endcase
  end

  always_comb begin
    mem_req = '0;
    unique case (state)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr;
        mem_req.rd_addr = own_slot;
      end
      S_WRITE: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_addr           = own_slot;
        mem_req.wr_data.by_impact = is_impact;
        mem_req.wr_data.ntime     = tsum;
        mem_req.rd_addr           = own_slot;
      end
      S_CMP0: begin
        mem_req.rd_addr = {4'd0, grp_first};
      end
      S_GRP: begin
        mem_req.rd_addr = {4'd0, 7'(grp_first + 7'(grp_k) + 7'd1)};
      end
      default: begin
        mem_req.rd_addr = own_slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      frame_counter <= '0;
      kick_start    <= '0;
      kick_held     <= 1'b0;
      muting_active <= 1'b0;
      out_valid     <= 1'b0;
      grp_k         <= '0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SLOT_BITS'(1);
          if (clr_addr == SLOT_BITS'(NOTE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            item  <= in_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          tsum  <= alu_resp.res;
          grp_k <= '0;
          if (item.mode == MODE_TICK) begin
            frame_counter <= alu_resp.res;
            state         <= S_TICK;
          end else if (item.mode == MODE_KICK) begin
            state <= S_IDLE;
            if (cmd == CMD_NOTE_ON) begin
              kick_held     <= 1'b1;
              kick_start    <= alu_resp.res;
              muting_active <= 1'b0;
            end else if (cmd == CMD_NOTE_OFF) begin
              kick_held <= 1'b0;
              if (!cfg.keep_mute_after_release) begin
                muting_active <= 1'b0;
              end
            end
          end else if (cmd == CMD_SYSTEM) begin
            state <= S_IDLE;
          end else begin
            if (demute) begin
              muting_active <= 1'b0;
            end
            if (cmd != CMD_NOTE_ON) begin
              state <= S_EMIT;
            end else if (is_impact || !muting_active || demute) begin
              state <= S_CMP0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CMP0: begin
          if (alu_resp.le && mem_rd.by_impact) begin
            state <= S_IDLE;
          end else if (in_snare || in_hat) begin
            state <= S_GRP;
          end else begin
            state <= S_WRITE;
          end
        end
        S_GRP: begin
          grp_k <= grp_k + 3'd1;
          if (alu_resp.le && (is_impact || mem_rd.by_impact)) begin
            state <= S_IDLE;
          end else if (grp_k == GROUP_LAST_K) begin
            state <= S_WRITE;
          end
        end
        S_TICK: begin
          if (kick_held && !alu_resp.lt) begin
            muting_active <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_WRITE: begin
          prod  <= 14'(item.velocity_in * cfg.velocity_gain);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_status <= item.status_byte;
      out_data.out_note   <= item.note_number;
      out_data.out_velocity <= (cmd == CMD_NOTE_ON) ? div127(prod) : item.velocity_in;
      out_data.out_frame  <= is_impact ? 12'd0 : item.frame_offset;
    end
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_DECODE)
    else $error("accepted item did not enter decode");
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall && !out_valid)
    else $error("activity during memory clear");
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == S_WRITE || state == S_CLEAR))
    else $error("note memory written outside write or clear");
  a_group_range: assert property (@(posedge clk) disable iff (rst)
    state == S_GRP |-> grp_k <= GROUP_LAST_K)
    else $error("group scan ran past its last entry");
`endif

endmodule

`default_nettype wire

[sim/drum_midi_retrigger_gate_top_tb.sv]
module drum_midi_retrigger_gate_top_tb;
  import drg_pkg::*;

  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;

  class gate_scoreboard;
    logic [TIME_BITS-1:0] note_time [NOTE_ENTRIES];
    bit                   note_by_impact [NOTE_ENTRIES];
    logic [TIME_BITS-1:0] frame_pos;
    logic [TIME_BITS-1:0] kick_start;
    bit                   kick_held;
    bit                   muting;
    logic [19:0]          spacing;
    logic [23:0]          open_len;
    bit                   keep_mute;
    logic [6:0]           gain;
    out_item_t            forwarded_q [$];
    int                   errors;

    function new();
      foreach (note_time[i]) begin
        note_time[i] = '0;
        note_by_impact[i] = 1'b0;
      end
      frame_pos = '0;
      kick_start = '0;
      kick_held = 1'b0;
      muting = 1'b0;
      spacing = '0;
      open_len = '0;
      keep_mute = 1'b0;
      gain = GAIN_RESET;
      errors = 0;
    endfunction

    function void set_config(logic [19:0] sp, logic [23:0] op, bit keep, logic [6:0] g);
      spacing = sp;
      open_len = op;
      keep_mute = keep;
      gain = g;
    endfunction

    function int pending();
      return forwarded_q.size();
    endfunction

    function bit is_recent(logic [10:0] slot, logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] diff;
      diff = now - note_time[slot];
      return diff <= TIME_BITS'(spacing);
    endfunction

    function bit group_hit(logic [6:0] first, logic [TIME_BITS-1:0] now, bit impact);
      logic [10:0] slot;
      for (int k = 0; k <= GROUP_LAST_K; k++) begin
        slot = 11'(first) + 11'(k);
        if (is_recent(slot, now) && (impact || note_by_impact[slot])) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_event(in_item_t it);
      logic [3:0]           cmd;
      logic [3:0]           chan;
      logic [TIME_BITS-1:0] stamp;
      logic [TIME_BITS-1:0] now;
      logic [10:0]          slot;
      logic [13:0]          product;
      bit                   impact;
      bit                   sounds;
      out_item_t            res;
      cmd = it.status_byte[7:4];
      chan = it.status_byte[3:0];
      impact = (it.mode == MODE_IMPACT);
      stamp = frame_pos + TIME_BITS'(it.frame_offset);
      if (it.mode == MODE_TICK) begin
        frame_pos = frame_pos + TIME_BITS'(it.tick_samples);
        if (kick_held && (frame_pos - kick_start) >= TIME_BITS'(open_len)) muting = 1'b1;
      end else if (it.mode == MODE_KICK) begin
        if (cmd == CMD_NOTE_ON) begin
          kick_held = 1'b1;
          kick_start = stamp;
          muting = 1'b0;
        end else if (cmd == CMD_NOTE_OFF) begin
          kick_held = 1'b0;
          if (!keep_mute) muting = 1'b0;
        end
      end else if (cmd != CMD_SYSTEM) begin
        if (!impact && !kick_held && muting && cmd == CMD_NOTE_ON && chan <= 4'd1 &&
            it.note_number < NOTE_DEMUTE_LIMIT) begin
          muting = 1'b0;
        end
        res.out_status = it.status_byte;
        res.out_note = it.note_number;
        res.out_velocity = it.velocity_in;
        res.out_frame = impact ? 12'd0 : it.frame_offset;
        sounds = 1'b1;
        if (cmd == CMD_NOTE_ON) begin
          if (!impact && muting) begin
            sounds = 1'b0;
          end else begin
            slot = {chan, it.note_number};
            now = impact ? frame_pos : stamp;
            if (is_recent(slot, now) && note_by_impact[slot]) sounds = 1'b0;
            if (chan == 4'd0 && it.note_number >= SNARE_FIRST && it.note_number <= SNARE_LAST &&
                group_hit(SNARE_FIRST, now, impact)) begin
              sounds = 1'b0;
            end
            if (chan == 4'd0 && it.note_number >= HAT_FIRST && it.note_number <= HAT_LAST &&
                group_hit(HAT_FIRST, now, impact)) begin
              sounds = 1'b0;
            end
            if (sounds) begin
              note_time[slot] = stamp;
              note_by_impact[slot] = impact;
              product = it.velocity_in * gain;
              res.out_velocity = 7'(product / 14'(VEL_DIVISOR));
            end
          end
        end
        if (sounds) forwarded_q.push_back(res);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (forwarded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer status %h note %h velocity %h frame %h",
                                  got.out_status, got.out_note, got.out_velocity, got.out_frame));
      end else begin
        want = forwarded_q.pop_front();
        if (got.out_status !== want.out_status)
          report_mismatch($sformatf("out_status got %h want %h", got.out_status, want.out_status));
        if (got.out_note !== want.out_note)
          report_mismatch($sformatf("out_note got %h want %h", got.out_note, want.out_note));
        if (got.out_velocity !== want.out_velocity)
          report_mismatch($sformatf("out_velocity got %h want %h",
                                    got.out_velocity, want.out_velocity));
        if (got.out_frame !== want.out_frame)
          report_mismatch($sformatf("out_frame got %h want %h", got.out_frame, want.out_frame));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_item_t                in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_item_t               out_data;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  gate_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  drum_midi_retrigger_gate_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_event(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic write_config(input logic [19:0] sp, input logic [23:0] op, input bit keep,
                              input logic [6:0] g);
    put_reg(REG_SPACING, CFG_BITS'(sp));
    put_reg(REG_OPEN, CFG_BITS'(op));
    put_reg(REG_KEEP, CFG_BITS'(keep));
    put_reg(REG_GAIN, CFG_BITS'(g));
    cfg_we <= 1'b0;
    sb.set_config(sp, op, keep, g);
  endtask

  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_fields(input logic [1:0] mode, input logic [7:0] status,
                             input logic [6:0] note, input logic [6:0] vel,
                             input logic [11:0] offs, input logic [13:0] ticks);
    in_item_t it;
    it.mode = mode;
    it.status_byte = status;
    it.note_number = note;
    it.velocity_in = vel;
    it.frame_offset = offs;
    it.tick_samples = ticks;
    send_item(it);
  endtask

  function automatic in_item_t random_event();
    in_item_t   it;
    int         pick;
    int         sub;
    logic [3:0] cmd;
    logic [3:0] chan;
    pick = $urandom_range(0, 99);
    it.mode = MODE_SEQ;
    it.status_byte = 8'($urandom_range(0, 255));
    it.note_number = 7'($urandom_range(0, 127));
    it.velocity_in = 7'($urandom_range(0, 127));
    it.frame_offset = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095)) :
                                                    12'($urandom_range(0, 255));
    it.tick_samples = 14'($urandom_range(0, 8192));
    if (pick < 6) begin
      it.mode = 2'($urandom_range(0, 3));
    end else if (pick < 20) begin
      it.mode = MODE_TICK;
      if ($urandom_range(0, 9) != 0) it.tick_samples = 14'($urandom_range(0, 400));
    end else if (pick < 27) begin
      it.mode = MODE_KICK;
      sub = $urandom_range(0, 11);
      cmd = (sub < 5) ? CMD_NOTE_ON : (sub < 10) ? CMD_NOTE_OFF : 4'($urandom_range(0, 15));
      it.status_byte = {cmd, 4'($urandom_range(0, 15))};
    end else begin
      it.mode = (pick < 65) ? MODE_SEQ : MODE_IMPACT;
      sub = $urandom_range(0, 9);
      chan = (sub < 6) ? 4'd0 : (sub < 8) ? 4'd1 : 4'($urandom_range(0, 15));
      sub = $urandom_range(0, 19);
      cmd = (sub < 14) ? CMD_NOTE_ON : (sub < 17) ? CMD_NOTE_OFF : 4'($urandom_range(0, 15));
      it.status_byte = {cmd, chan};
      if ($urandom_range(0, 9) < 7) it.note_number = 7'($urandom_range(34, 52));
    end
    return it;
  endfunction

  task automatic run_events(input int count);
    for (int n = 0; n < count; n++) send_item(random_event());
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_config(20'd64, 24'd0, 1'b0, 7'd127);
    send_idle_pct = 21;
    recv_idle_pct <= 47;
    send_fields(MODE_SEQ, 8'h90, 7'd60, 7'd127, 12'd0, 14'd0);
    send_fields(MODE_IMPACT, 8'h90, 7'd38, 7'd100, 12'd0, 14'd0);
    send_fields(MODE_TICK, 8'h00, 7'd0, 7'd0, 12'd0, 14'd8192);
    send_fields(MODE_IMPACT, 8'h90, 7'd38, 7'd1, 12'd77, 14'd0);
    send_fields(MODE_SEQ, 8'h90, 7'd40, 7'd90, 12'd10, 14'd0);
    send_fields(MODE_SEQ, 8'h90, 7'd38, 7'd64, 12'd4095, 14'd0);
    send_fields(MODE_SEQ, 8'hF8, 7'd0, 7'd0, 12'd3, 14'd0);
    send_fields(MODE_IMPACT, 8'hFF, 7'd127, 7'd127, 12'd4095, 14'd16383);
    send_fields(MODE_SEQ, 8'hB5, 7'd7, 7'd99, 12'd300, 14'd0);
    send_fields(MODE_IMPACT, 8'hE3, 7'd0, 7'd127, 12'd4095, 14'd0);
    send_fields(MODE_SEQ, 8'h80, 7'd60, 7'd64, 12'd5, 14'd0);
    send_fields(MODE_SEQ, 8'h90, 7'd50, 7'd0, 12'd6, 14'd0);
    send_fields(MODE_IMPACT, 8'h92, 7'd60, 7'd80, 12'd9, 14'd0);
    send_fields(MODE_SEQ, 8'h92, 7'd60, 7'd80, 12'd20, 14'd0);
    send_fields(MODE_IMPACT, 8'h90, 7'd44, 7'd90, 12'd0, 14'd0);
    send_fields(MODE_SEQ, 8'h90, 7'd47, 7'd90, 12'd30, 14'd0);
    send_fields(MODE_SEQ, 8'h9F, 7'd127, 7'd127, 12'd4095, 14'd8192);
    send_fields(MODE_KICK, 8'h90, 7'd36, 7'd100, 12'd0, 14'd0);
    send_fields(MODE_KICK, 8'hA0, 7'd36, 7'd100, 12'd0, 14'd0);
    send_fields(MODE_TICK, 8'h00, 7'd0, 7'd0, 12'd0, 14'd0);
    send_fields(MODE_SEQ, 8'h90, 7'd36, 7'd100, 12'd0, 14'd0);
    send_fields(MODE_IMPACT, 8'h90, 7'd70, 7'd100, 12'd0, 14'd0);
    send_fields(MODE_SEQ, 8'hB0, 7'd64, 7'd127, 12'd1, 14'd0);
    send_fields(MODE_KICK, 8'h80, 7'd36, 7'd0, 12'd0, 14'd0);
    send_fields(MODE_SEQ, 8'h91, 7'd42, 7'd127, 12'd0, 14'd0);
    in_valid <= 1'b0;
    settle();

    write_config(20'd300, 24'd1000, 1'b1, 7'd100);
    run_events(280);
    settle();

    write_config(20'hFFFFF, 24'hFFFFFF, 1'b0, 7'd0);
    send_idle_pct = 47;
    recv_idle_pct <= 21;
    run_events(280);
    settle();

    // The output side holds off for a long stretch while items keep coming.
    write_config(20'd0, 24'd0, 1'b1, 7'd127);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= hold_req + 1;
    run_events(150);
    do @(posedge clk); while (sb.pending() != 0);
    run_events(140);
    settle();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/drg_pkg.sv
rtl/drg_alu.sv
rtl/drg_note_mem.sv
rtl/drg_seq.sv
rtl/drum_midi_retrigger_gate_top.sv
sim/drum_midi_retrigger_gate_top_tb.sv
